FILE: sv/rau_pkg.sv
// Shared types, codes and helper functions for the rational arithmetic unit.
package rau_pkg;

  // Newton iteration count for the square root operation.
  localparam int SQRT_STEPS = 25;
  localparam int STEP_W     = $clog2(SQRT_STEPS + 1);

  // Divider word width and its iteration counter width.
  localparam int DIV_W   = 32;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  // Operation codes.
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_NEG   = 4'd4;
  localparam logic [3:0] OP_INC   = 4'd5;
  localparam logic [3:0] OP_DEC   = 4'd6;
  localparam logic [3:0] OP_EQ    = 4'd7;
  localparam logic [3:0] OP_NE    = 4'd8;
  localparam logic [3:0] OP_LT    = 4'd9;
  localparam logic [3:0] OP_LE    = 4'd10;
  localparam logic [3:0] OP_GT    = 4'd11;
  localparam logic [3:0] OP_GE    = 4'd12;
  localparam logic [3:0] OP_SQRT  = 4'd13;
  localparam logic [3:0] OP_TOINT = 4'd14;
  localparam logic [3:0] OP_NOP   = 4'd15;

  // Error codes.
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ZERO = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;
  localparam logic [1:0] ERR_SQRT = 2'd3;

  // Datapath command codes.
  localparam logic [4:0] C_NONE     = 5'd0;
  localparam logic [4:0] C_LOAD     = 5'd1;
  localparam logic [4:0] C_ERR1     = 5'd2;
  localparam logic [4:0] C_W_A      = 5'd3;
  localparam logic [4:0] C_W_B      = 5'd4;
  localparam logic [4:0] C_ST_A     = 5'd5;
  localparam logic [4:0] C_ST_B     = 5'd6;
  localparam logic [4:0] C_RECIP    = 5'd7;
  localparam logic [4:0] C_ADD_SAME = 5'd8;
  localparam logic [4:0] C_ADD_PQ   = 5'd9;
  localparam logic [4:0] C_WD_P     = 5'd10;
  localparam logic [4:0] C_MUL_WR   = 5'd11;
  localparam logic [4:0] C_NEG      = 5'd12;
  localparam logic [4:0] C_INC      = 5'd13;
  localparam logic [4:0] C_DEC      = 5'd14;
  localparam logic [4:0] C_CMP      = 5'd15;
  localparam logic [4:0] C_SQ_ERR3  = 5'd16;
  localparam logic [4:0] C_SQ_NEG1  = 5'd17;
  localparam logic [4:0] C_SQ_INIT  = 5'd18;
  localparam logic [4:0] C_SQ_X     = 5'd19;
  localparam logic [4:0] C_SQ_Y     = 5'd20;
  localparam logic [4:0] C_SQ_DONE  = 5'd21;
  localparam logic [4:0] C_R_INIT   = 5'd22;
  localparam logic [4:0] C_R_GSTEP  = 5'd23;
  localparam logic [4:0] C_R_QN     = 5'd24;
  localparam logic [4:0] C_R_FIX    = 5'd25;
  localparam logic [4:0] C_ST_RES   = 5'd26;
  localparam logic [4:0] C_TI_WR    = 5'd27;
  localparam logic [4:0] C_PUB      = 5'd28;

  // Multiplier operand pairs.
  localparam logic [2:0] M_AN_BD = 3'd0;
  localparam logic [2:0] M_AD_B2 = 3'd1;
  localparam logic [2:0] M_AD_BD = 3'd2;
  localparam logic [2:0] M_AN_BN = 3'd3;
  localparam logic [2:0] M_BN_AD = 3'd4;

  // Divider operand pairs.
  localparam logic [2:0] D_GCD   = 3'd0;
  localparam logic [2:0] D_DN    = 3'd1;
  localparam logic [2:0] D_DD    = 3'd2;
  localparam logic [2:0] D_SQX   = 3'd3;
  localparam logic [2:0] D_SQY   = 3'd4;
  localparam logic [2:0] D_TOINT = 3'd5;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic [1:0]         error_code;
  } rau_out_t;

  typedef struct packed {
    logic [4:0] code;
    logic       mul_en;
    logic       mul_to_q;
    logic [2:0] mul_sel;
    logic       div_start;
    logic [2:0] div_sel;
  } rau_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       zero_err;
    logic       err_nz;
    logic       same_den;
    logic       div_done;
    logic       div_busy;
    logic       gy_zero;
    logic       bn_zero;
    logic       bn_neg;
    logic       bn_m1;
    logic       step_last;
  } rau_sts_t;

  // True when a wide signed value fits in 32 signed bits.
  function automatic logic fits32(input logic signed [67:0] v);
    return (&v[67:31]) | ~(|v[67:31]);
  endfunction

  // Magnitude of a 32-bit signed value; the most negative value gives 2^31.
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

FILE: sv/rau_div.sv
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit per cycle.
module rau_div import rau_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder,
  output logic             busy,
  output logic             done
);

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W:0]    trial;
  logic              ge;

  // One shift-and-subtract step.
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // Control: iteration count, busy and the one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign busy      = busy_r;
  assign done      = done_r;

endmodule

FILE: sv/rau_datapath.sv
// Operand, work and result registers with the shared multiplier and divider.
module rau_datapath import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rau_cmd_t cmd,
  input  rau_in_t  in_data,
  output rau_sts_t sts,
  output rau_out_t out_data
);

  logic [3:0]         op_r;
  logic signed [31:0] an_r, ad_r, bn_r, bd_r;
  logic signed [31:0] wn_r, wd_r;
  logic signed [31:0] rn_r, rd_r;
  logic [31:0]        gx_r, gy_r, qn_r, x_r, y_r;
  logic signed [65:0] p_r, q_r;
  logic [1:0]         err_r;
  logic               cmp_r;
  logic [STEP_W-1:0]  step_r;
  rau_out_t           out_r;

  logic signed [32:0] an33, ad33, bn33, bd33, b2;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [33:0] s_same;
  logic signed [67:0] p68, q68, sum68, diff68;
  logic [31:0]        dvd, dvs, dq, drem;
  logic               d_busy, d_done;
  logic [32:0]        sx, sy;
  logic               fix_neg;
  logic               use_a, use_b;
  logic               cmp_lt, cmp_zero, cmp_val;
  rau_out_t           pub;

  // Sign-extended operands for the multiplier.
  assign an33 = {an_r[31], an_r};
  assign ad33 = {ad_r[31], ad_r};
  assign bn33 = {bn_r[31], bn_r};
  assign bd33 = {bd_r[31], bd_r};
  assign b2   = (op_r == OP_SUB) ? -bn33 : bn33;

  // Multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      M_AN_BD: begin ma = an33; mb = bd33; end
      M_AD_B2: begin ma = ad33; mb = b2;   end
      M_AD_BD: begin ma = ad33; mb = bd33; end
      M_AN_BN: begin ma = an33; mb = bn33; end
      M_BN_AD: begin ma = bn33; mb = ad33; end
      default: begin ma = an33; mb = bd33; end
    endcase
  end

  assign prod = ma * mb;

  // Wide sum and difference of the registered products, and the same-denominator sum.
  assign p68    = 68'(p_r);
  assign q68    = 68'(q_r);
  assign sum68  = p68 + q68;
  assign diff68 = p68 - q68;
  assign s_same = 34'(an33) + 34'(b2);

  // Divider operand selection.
  always_comb begin
    case (cmd.div_sel)
      D_GCD:   begin dvd = gx_r;        dvs = gy_r; end
      D_DN:    begin dvd = abs32(wn_r); dvs = gx_r; end
      D_DD:    begin dvd = abs32(wd_r); dvs = gx_r; end
      D_SQX:   begin dvd = bn_r;        dvs = x_r;  end
      D_SQY:   begin dvd = bd_r;        dvs = y_r;  end
      D_TOINT: begin dvd = abs32(an_r); dvs = ad_r; end
      default: begin dvd = gx_r;        dvs = gy_r; end
    endcase
  end

  rau_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .quotient  (dq),
    .remainder (drem),
    .busy      (d_busy),
    .done      (d_done)
  );

  // Newton updates and sign of the reduced fraction.
  assign sx      = {1'b0, x_r} + {1'b0, dq};
  assign sy      = {1'b0, y_r} + {1'b0, dq};
  assign fix_neg = wn_r[31] ^ wd_r[31];

  // Comparison outcome from the exact cross difference.
  always_comb begin
    cmp_lt   = diff68[67];
    cmp_zero = diff68 == '0;
    case (op_r)
      OP_EQ:   cmp_val = cmp_zero;
      OP_NE:   cmp_val = !cmp_zero;
      OP_LT:   cmp_val = cmp_lt;
      OP_LE:   cmp_val = cmp_lt | cmp_zero;
      OP_GT:   cmp_val = !(cmp_lt | cmp_zero);
      default: cmp_val = !cmp_lt;
    endcase
  end

  // Result beat; an error clears every value field.
  always_comb begin
    pub = '0;
    pub.error_code = err_r;
    if (err_r == ERR_OK) begin
      pub.res_num      = rn_r;
      pub.res_den      = rd_r[30:0];
      pub.compare_true = cmp_r;
    end
  end

  // Register updates per command.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_to_q) begin
        q_r <= prod;
      end else begin
        p_r <= prod;
      end
    end
    case (cmd.code)
      C_LOAD: begin
        op_r  <= in_data.operation;
        an_r  <= in_data.a_num;
        ad_r  <= in_data.a_den;
        bn_r  <= in_data.b_num;
        bd_r  <= in_data.b_den;
        err_r <= ERR_OK;
        cmp_r <= 1'b0;
        rn_r  <= '0;
        rd_r  <= '0;
      end
      C_ERR1: err_r <= ERR_ZERO;
      C_W_A: begin
        wn_r <= an_r;
        wd_r <= ad_r;
      end
      C_W_B: begin
        wn_r <= bn_r;
        wd_r <= bd_r;
      end
      C_ST_A: begin
        an_r <= wn_r;
        ad_r <= wd_r;
      end
      C_ST_B: begin
        bn_r <= wn_r;
        bd_r <= wd_r;
      end
      C_RECIP: begin
        if (bn_r == {1'b1, 31'd0}) begin
          err_r <= ERR_OVF;
        end else begin
          bn_r <= bn_r[31] ? -bd_r : bd_r;
          bd_r <= abs32(bn_r);
        end
      end
      C_ADD_SAME: begin
        wn_r <= s_same[31:0];
        wd_r <= ad_r;
        if (!fits32(68'(s_same))) err_r <= ERR_OVF;
      end
      C_ADD_PQ: begin
        wn_r <= sum68[31:0];
        if (!(fits32(p68) && fits32(q68) && fits32(sum68))) err_r <= ERR_OVF;
      end
      C_WD_P: begin
        wd_r <= p_r[31:0];
        if (!fits32(p68)) err_r <= ERR_OVF;
      end
      C_MUL_WR: begin
        wn_r <= p_r[31:0];
        wd_r <= q_r[31:0];
        if (!(fits32(p68) && fits32(q68))) err_r <= ERR_OVF;
      end
      C_NEG: begin
        if (an_r == {1'b1, 31'd0}) begin
          err_r <= ERR_OVF;
        end else begin
          rn_r <= -an_r;
          rd_r <= ad_r;
        end
      end
      C_INC: begin
        rn_r <= an_r + ad_r;
        rd_r <= ad_r;
      end
      C_DEC: begin
        rn_r <= an_r - ad_r;
        rd_r <= ad_r;
      end
      C_CMP: cmp_r <= cmp_val;
      C_SQ_ERR3: err_r <= ERR_SQRT;
      C_SQ_NEG1: begin
        rn_r <= '0;
        rd_r <= 32'sd1;
      end
      C_SQ_INIT: begin
        x_r    <= bn_r;
        y_r    <= bd_r;
        step_r <= '0;
      end
      C_SQ_X: x_r <= sx[32:1];
      C_SQ_Y: begin
        y_r    <= sy[32:1];
        step_r <= step_r + 1'b1;
      end
      C_SQ_DONE: begin
        wn_r <= x_r;
        wd_r <= y_r;
      end
      C_R_INIT: begin
        gx_r <= abs32(wn_r);
        gy_r <= abs32(wd_r);
      end
      C_R_GSTEP: begin
        gx_r <= gy_r;
        gy_r <= drem;
      end
      C_R_QN: qn_r <= dq;
      C_R_FIX: begin
        // A magnitude of 2^31 survives only as a negative numerator.
        if (dq[31] || (!fix_neg && qn_r[31])) begin
          err_r <= ERR_OVF;
        end else begin
          wn_r <= fix_neg ? (~qn_r + 32'd1) : qn_r;
          wd_r <= dq;
        end
      end
      C_ST_RES: begin
        rn_r <= wn_r;
        rd_r <= wd_r;
      end
      C_TI_WR: begin
        rn_r <= an_r[31] ? (~dq + 32'd1) : dq;
        rd_r <= 32'sd1;
      end
      C_PUB: out_r <= pub;
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    use_a = op_r != OP_SQRT && op_r != OP_NOP;
    use_b = op_r inside {[OP_ADD:OP_DIV], [OP_EQ:OP_TOINT]};
    sts           = '0;
    sts.op        = op_r;
    sts.zero_err  = (use_a && ad_r == '0) || (use_b && bd_r == '0) ||
                    (op_r == OP_DIV && bn_r == '0);
    sts.err_nz    = err_r != ERR_OK;
    sts.same_den  = ad_r == bd_r;
    sts.div_done  = d_done;
    sts.div_busy  = d_busy;
    sts.gy_zero   = gy_r == '0;
    sts.bn_zero   = bn_r == '0;
    sts.bn_neg    = bn_r[31];
    sts.bn_m1     = &bn_r;
    sts.step_last = step_r == STEP_W'(SQRT_STEPS - 1);
  end

  assign out_data = out_r;

endmodule

FILE: sv/rau_ctrl.sv
// Sequencing state machine that issues datapath commands and owns both handshakes.
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_stall,
  input  rau_sts_t sts,
  output rau_cmd_t cmd,
  output logic     in_stall,
  output logic     out_valid
);

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_CHECK  = 6'd1;
  localparam logic [5:0] S_RA     = 6'd2;
  localparam logic [5:0] S_RA2    = 6'd3;
  localparam logic [5:0] S_RB     = 6'd4;
  localparam logic [5:0] S_OP     = 6'd5;
  localparam logic [5:0] S_DCHK   = 6'd6;
  localparam logic [5:0] S_AQ     = 6'd7;
  localparam logic [5:0] S_ASUM   = 6'd8;
  localparam logic [5:0] S_AWD    = 6'd9;
  localparam logic [5:0] S_MQ     = 6'd10;
  localparam logic [5:0] S_MWR    = 6'd11;
  localparam logic [5:0] S_CQ     = 6'd12;
  localparam logic [5:0] S_CMP    = 6'd13;
  localparam logic [5:0] S_SQ0    = 6'd14;
  localparam logic [5:0] S_SQX    = 6'd15;
  localparam logic [5:0] S_SQXW   = 6'd16;
  localparam logic [5:0] S_SQY    = 6'd17;
  localparam logic [5:0] S_SQYW   = 6'd18;
  localparam logic [5:0] S_SQD    = 6'd19;
  localparam logic [5:0] S_TI     = 6'd20;
  localparam logic [5:0] S_TIW    = 6'd21;
  localparam logic [5:0] S_CHKRED = 6'd22;
  localparam logic [5:0] S_RI     = 6'd23;
  localparam logic [5:0] S_RG     = 6'd24;
  localparam logic [5:0] S_RGW    = 6'd25;
  localparam logic [5:0] S_RDN    = 6'd26;
  localparam logic [5:0] S_RDNW   = 6'd27;
  localparam logic [5:0] S_RDD    = 6'd28;
  localparam logic [5:0] S_RDDW   = 6'd29;
  localparam logic [5:0] S_RES    = 6'd30;
  localparam logic [5:0] S_FIN    = 6'd31;

  logic [5:0] state_r, state_nxt;
  logic [5:0] ret_r, ret_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       use_a, use_b;

  assign use_a = sts.op != OP_SQRT;
  assign use_b = sts.op inside {[OP_ADD:OP_DIV], [OP_EQ:OP_TOINT]};

  // Next state and command for the current step.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.code  = C_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op == OP_NOP) begin
          state_nxt = S_FIN;
        end else if (sts.zero_err) begin
          cmd.code  = C_ERR1;
          state_nxt = S_FIN;
        end else if (use_a) begin
          cmd.code  = C_W_A;
          ret_nxt   = S_RA;
          state_nxt = S_RI;
        end else begin
          cmd.code  = C_W_B;
          ret_nxt   = S_RB;
          state_nxt = S_RI;
        end
      end
      S_RA: begin
        if (sts.err_nz) begin
          state_nxt = S_FIN;
        end else begin
          cmd.code  = C_ST_A;
          state_nxt = use_b ? S_RA2 : S_OP;
        end
      end
      S_RA2: begin
        cmd.code  = C_W_B;
        ret_nxt   = S_RB;
        state_nxt = S_RI;
      end
      S_RB: begin
        if (sts.err_nz) begin
          state_nxt = S_FIN;
        end else begin
          cmd.code  = C_ST_B;
          state_nxt = S_OP;
        end
      end
      // Dispatch on the operation once its operands are reduced.
      S_OP: begin
        case (sts.op)
          OP_ADD, OP_SUB: begin
            if (sts.same_den) begin
              cmd.code  = C_ADD_SAME;
              state_nxt = S_CHKRED;
            end else begin
              cmd.mul_en  = 1'b1;
              cmd.mul_sel = M_AN_BD;
              state_nxt   = S_AQ;
            end
          end
          OP_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = M_AN_BN;
            state_nxt   = S_MQ;
          end
          OP_DIV: begin
            cmd.code  = C_RECIP;
            state_nxt = S_DCHK;
          end
          OP_NEG: begin
            cmd.code  = C_NEG;
            state_nxt = S_FIN;
          end
          OP_INC: begin
            cmd.code  = C_INC;
            state_nxt = S_FIN;
          end
          OP_DEC: begin
            cmd.code  = C_DEC;
            state_nxt = S_FIN;
          end
          OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = M_AN_BD;
            state_nxt   = S_CQ;
          end
          OP_SQRT:  state_nxt = S_SQ0;
          OP_TOINT: state_nxt = S_TI;
          default:  state_nxt = S_FIN;
        endcase
      end
      S_DCHK: begin
        if (sts.err_nz) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = M_AN_BN;
          state_nxt   = S_MQ;
        end
      end
      // Cross-multiplied sum for unequal denominators.
      S_AQ: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_to_q = 1'b1;
        cmd.mul_sel  = M_AD_B2;
        state_nxt    = S_ASUM;
      end
      S_ASUM: begin
        cmd.code    = C_ADD_PQ;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = M_AD_BD;
        state_nxt   = S_AWD;
      end
      S_AWD: begin
        cmd.code  = C_WD_P;
        state_nxt = S_CHKRED;
      end
      S_MQ: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_to_q = 1'b1;
        cmd.mul_sel  = M_AD_BD;
        state_nxt    = S_MWR;
      end
      S_MWR: begin
        cmd.code  = C_MUL_WR;
        state_nxt = S_CHKRED;
      end
      S_CQ: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_to_q = 1'b1;
        cmd.mul_sel  = M_BN_AD;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.code  = C_CMP;
        state_nxt = S_FIN;
      end
      // Square root: a non-positive radicand never converges.
      S_SQ0: begin
        if (sts.bn_zero || (sts.bn_neg && !sts.bn_m1)) begin
          cmd.code  = C_SQ_ERR3;
          state_nxt = S_FIN;
        end else if (sts.bn_m1) begin
          cmd.code  = (SQRT_STEPS > 1) ? C_SQ_ERR3 : C_SQ_NEG1;
          state_nxt = S_FIN;
        end else begin
          cmd.code  = C_SQ_INIT;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = D_SQX;
        state_nxt     = S_SQXW;
      end
      S_SQXW: begin
        if (sts.div_done) begin
          cmd.code  = C_SQ_X;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = D_SQY;
        state_nxt     = S_SQYW;
      end
      S_SQYW: begin
        if (sts.div_done) begin
          cmd.code  = C_SQ_Y;
          state_nxt = sts.step_last ? S_SQD : S_SQX;
        end
      end
      S_SQD: begin
        cmd.code  = C_SQ_DONE;
        ret_nxt   = S_RES;
        state_nxt = S_RI;
      end
      S_TI: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = D_TOINT;
        state_nxt     = S_TIW;
      end
      S_TIW: begin
        if (sts.div_done) begin
          cmd.code  = C_TI_WR;
          state_nxt = S_FIN;
        end
      end
      S_CHKRED: begin
        if (sts.err_nz) begin
          state_nxt = S_FIN;
        end else begin
          ret_nxt   = S_RES;
          state_nxt = S_RI;
        end
      end
      // Reduction: Euclid on magnitudes, then divide both terms by the GCD.
      S_RI: begin
        cmd.code  = C_R_INIT;
        state_nxt = S_RG;
      end
      S_RG: begin
        if (sts.gy_zero) begin
          state_nxt = S_RDN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = D_GCD;
          state_nxt     = S_RGW;
        end
      end
      S_RGW: begin
        if (sts.div_done) begin
          cmd.code  = C_R_GSTEP;
          state_nxt = S_RG;
        end
      end
      S_RDN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = D_DN;
        state_nxt     = S_RDNW;
      end
      S_RDNW: begin
        if (sts.div_done) begin
          cmd.code  = C_R_QN;
          state_nxt = S_RDD;
        end
      end
      S_RDD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = D_DD;
        state_nxt     = S_RDDW;
      end
      S_RDDW: begin
        if (sts.div_done) begin
          cmd.code  = C_R_FIX;
          state_nxt = ret_r;
        end
      end
      S_RES: begin
        cmd.code  = C_ST_RES;
        state_nxt = S_FIN;
      end
      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.code  = C_PUB;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid follows publish and the downstream accept.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.code == C_PUB) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

FILE: sv/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: controller, datapath and checks.
//
//   channel  direction  handshake           beat
//   in       input      in_valid/in_stall   rau_in_t: operation, a_num, a_den, b_num, b_den
//   out      output     out_valid/out_stall rau_out_t: res_num, res_den, compare_true,
//                                           error_code
//
// One item at a time. Every division runs on one shared radix-2 divider. A reduction
// costs one division per Euclid step plus two more divisions; Euclid needs at most
// about 46 steps on 32-bit magnitudes. An item reduces up to two operands and one
// result, and sqrt adds 50 divisions.
// Reset is synchronous and active low and clears the controller and divider state.
// A finished beat waits in the output register while the next item is accepted.
module rational_arithmetic_unit_core import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rau_out_t out_data
);

  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  rau_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

  // An accepted beat keeps the input side stalled while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again right after a beat");

  // The shared divider is never restarted while it is still iterating.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // A result is only published when the output register can take it.
  a_pub_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.code == C_PUB) |-> (!out_valid || !out_stall))
    else $error("result published over a stalled beat");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the rational arithmetic unit core.
module testbench;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] IMAX = 32'sh7fffffff;
  localparam logic signed [31:0] IMIN = 32'sh80000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rau_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rau_out_t out_data;

  rau_out_t expected_q[$];
  int       mismatch_count;
  bit       stim_done;

  rational_arithmetic_unit_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fitting check on 64-bit intermediates.
  function automatic bit in_range(input longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  function automatic longint gcd64(input longint x, input longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Lowest terms with positive denominator; returns an error code.
  function automatic logic [1:0] lowest_terms(inout longint n, inout longint d);
    longint g;
    g = gcd64(n < 0 ? -n : n, d < 0 ? -d : d);
    if (g == 0) return ERR_ZERO;
    n = n / g;
    d = d / g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    return (in_range(n) && in_range(d)) ? ERR_OK : ERR_OVF;
  endfunction

  // Exact rational result of one operation.
  function automatic rau_out_t rational_result(input rau_in_t it);
    longint an, ad, bn, bd, rn, rd, p, q, b2, x, y, t, diff;
    logic [1:0] err;
    bit cmp, use_a, use_b;
    rau_out_t r;
    an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
    rn = 0; rd = 0; cmp = 0; err = ERR_OK;
    if (it.operation != OP_NOP) begin
      use_a = it.operation != OP_SQRT;
      use_b = it.operation <= OP_DIV || it.operation >= OP_EQ;
      if ((use_a && ad == 0) || (use_b && bd == 0)) err = ERR_ZERO;
      else if (it.operation == OP_DIV && bn == 0) err = ERR_ZERO;
      else begin
        if (use_a) err = lowest_terms(an, ad);
        if (err == ERR_OK && use_b) err = lowest_terms(bn, bd);
      end
      if (err == ERR_OK && it.operation == OP_DIV) begin
        t = bd; bd = bn; bn = t;
        if (bd < 0) begin
          bn = -bn;
          bd = -bd;
        end
        if (!in_range(bn) || !in_range(bd)) err = ERR_OVF;
      end
      if (err == ERR_OK) begin
        case (it.operation)
          OP_ADD, OP_SUB: begin
            b2 = (it.operation == OP_SUB) ? -bn : bn;
            if (ad == bd) begin
              rn = an + b2;
              rd = ad;
              if (!in_range(rn)) err = ERR_OVF;
            end else begin
              p = an * bd;
              q = ad * b2;
              rd = ad * bd;
              rn = p + q;
              if (!in_range(p) || !in_range(q) || !in_range(rn) || !in_range(rd))
                err = ERR_OVF;
            end
            if (err == ERR_OK) err = lowest_terms(rn, rd);
          end
          OP_MUL, OP_DIV: begin
            rn = an * bn;
            rd = ad * bd;
            if (!in_range(rn) || !in_range(rd)) err = ERR_OVF;
            else err = lowest_terms(rn, rd);
          end
          OP_NEG: begin
            rn = -an;
            rd = ad;
            if (!in_range(rn)) err = ERR_OVF;
          end
          OP_INC: begin
            rn = longint'(signed'(32'(an + ad)));
            rd = ad;
          end
          OP_DEC: begin
            rn = longint'(signed'(32'(an - ad)));
            rd = ad;
          end
          OP_SQRT: begin
            x = bn; y = bd;
            for (int i = 0; i < SQRT_STEPS; i++) begin
              if (x == 0 || y == 0 || bn / x < 0 || bd / y < 0) begin
                err = ERR_SQRT;
                break;
              end
              x = (x + bn / x) / 2;
              y = (y + bd / y) / 2;
              if (x < 0 || y < 0) begin
                err = ERR_SQRT;
                break;
              end
            end
            if (err == ERR_OK) begin
              if (y == 0) err = ERR_SQRT;
              else begin
                rn = x;
                rd = y;
                err = lowest_terms(rn, rd);
              end
            end
          end
          OP_TOINT: begin
            rn = an / ad;
            rd = 1;
          end
          default: begin
            diff = an * bd - bn * ad;
            case (it.operation)
              OP_EQ: cmp = diff == 0;
              OP_NE: cmp = diff != 0;
              OP_LT: cmp = diff < 0;
              OP_LE: cmp = diff <= 0;
              OP_GT: cmp = diff > 0;
              default: cmp = diff >= 0;
            endcase
          end
        endcase
      end
    end
    if (err != ERR_OK) begin
      rn = 0;
      rd = 0;
      cmp = 0;
    end
    r.res_num = rn[31:0];
    r.res_den = rd[30:0];
    r.compare_true = cmp;
    r.error_code = err;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // Directed rows: expected value typed in where obvious, else predicted.
  typedef struct {
    rau_in_t  beat;
    bit       has_want;
    rau_out_t want;
  } row_t;
  row_t rows[$];

  task automatic add_row(input logic [3:0] op, input logic signed [31:0] an,
                         input logic signed [31:0] ad, input logic signed [31:0] bn,
                         input logic signed [31:0] bd, input bit hw,
                         input logic signed [31:0] rn, input logic [30:0] rd,
                         input bit c, input logic [1:0] e);
    row_t r;
    r.beat = '{op, an, ad, bn, bd};
    r.has_want = hw;
    r.want = '{rn, rd, c, e};
    rows.push_back(r);
  endtask

  // Sends one beat and queues its expected result; valid stays high into a zero gap.
  task automatic send_beat(input rau_in_t b, input bit hw, input rau_out_t w);
    rau_out_t p;
    int       n;
    p = rational_result(b);
    if (hw && p != w) report_mismatch("directed row", 64'(p), 64'(w));
    expected_q.push_back(hw ? w : p);
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(1, 1000);
      2: return $urandom_range(0, 4) == 0 ? IMIN : IMAX - $urandom_range(0, 2);
      3: return $urandom_range(1, 65535) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus.
  initial begin
    rau_in_t b;
    rau_out_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stim_done = 1'b0;
    mismatch_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_row(OP_ADD, 1, 2, 1, 3, 1, 5, 6, 0, ERR_OK);
    add_row(OP_SUB, 1, 2, 1, 2, 1, 0, 1, 0, ERR_OK);
    add_row(OP_MUL, 2, 3, 3, 4, 1, 1, 2, 0, ERR_OK);
    add_row(OP_DIV, 1, 2, 0, 5, 1, 0, 0, 0, ERR_ZERO);
    add_row(OP_DIV, 1, 2, IMIN, 1, 1, 0, 0, 0, ERR_OVF);
    add_row(OP_NEG, IMIN, 1, 0, 1, 1, 0, 0, 0, ERR_OVF);
    add_row(OP_INC, IMAX, 1, 0, 0, 1, IMIN, 1, 0, ERR_OK);
    add_row(OP_DEC, IMIN, 1, 0, 0, 1, IMAX, 1, 0, ERR_OK);
    add_row(OP_EQ, 1, 2, 2, 4, 1, 0, 0, 1, ERR_OK);
    add_row(OP_NE, 1, 2, 2, 4, 0, 0, 0, 0, ERR_OK);
    add_row(OP_LT, -1, 3, 1, 3, 0, 0, 0, 0, ERR_OK);
    add_row(OP_LE, IMAX, 1, IMAX, 1, 0, 0, 0, 0, ERR_OK);
    add_row(OP_GT, IMAX, 1, IMIN + 1, 1, 0, 0, 0, 0, ERR_OK);
    add_row(OP_GE, -5, 7, -5, 7, 0, 0, 0, 0, ERR_OK);
    add_row(OP_SQRT, 0, 0, 16, 9, 0, 0, 0, 0, ERR_OK);
    add_row(OP_SQRT, 0, 0, -4, 1, 1, 0, 0, 0, ERR_SQRT);
    add_row(OP_SQRT, 0, 0, 0, 1, 1, 0, 0, 0, ERR_SQRT);
    add_row(OP_TOINT, -7, 2, 0, 1, 1, -3, 1, 0, ERR_OK);
    add_row(OP_NOP, IMAX, 0, IMIN, 0, 1, 0, 0, 0, ERR_OK);
    add_row(OP_ADD, 1, 0, 1, 1, 1, 0, 0, 0, ERR_ZERO);
    add_row(OP_MUL, 4, -6, 3, 9, 0, 0, 0, 0, ERR_OK);
    add_row(OP_NEG, IMIN, IMIN, 0, 1, 0, 0, 0, 0, ERR_OK);
    add_row(OP_MUL, IMAX, 1, IMAX, 1, 1, 0, 0, 0, ERR_OVF);
    add_row(OP_ADD, IMIN, -1, 0, 1, 1, 0, 0, 0, ERR_OVF);
    add_row(OP_SUB, 0, 1, IMIN, 1, 1, 0, 0, 0, ERR_OVF);
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_want, rows[i].want);
    // Random items: mostly well-formed small fractions, some wild words.
    repeat (1350) begin
      b.operation = 4'($urandom_range(0, 15));
      b.a_num = rand_word($urandom_range(0, 4));
      b.a_den = rand_word($urandom_range(0, 7) == 0 ? $urandom_range(0, 4) : 1);
      b.b_num = rand_word($urandom_range(0, 4));
      b.b_den = rand_word($urandom_range(0, 7) == 0 ? $urandom_range(0, 4) : 1);
      send_beat(b, 1'b0, none);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls and in-order comparison.
  initial begin
    rau_out_t w;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_q.size() == 0) report_mismatch("unexpected beat", 64'(out_data), 0);
        else begin
          w = expected_q.pop_front();
          if (out_data.res_num !== w.res_num)
            report_mismatch("res_num", out_data.res_num, w.res_num);
          if (out_data.res_den !== w.res_den)
            report_mismatch("res_den", out_data.res_den, w.res_den);
          if (out_data.compare_true !== w.compare_true)
            report_mismatch("compare_true", out_data.compare_true, w.compare_true);
          if (out_data.error_code !== w.error_code)
            report_mismatch("error_code", out_data.error_code, w.error_code);
        end
      end
      out_stall <= ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 9) == 0) : 1'b0;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0)
      $display("rational_arithmetic_unit_core: match");
    else
      $display("rational_arithmetic_unit_core: mismatch");
    $finish;
  end

  // Watchdog.
  initial begin
    #400_000_000;
    $display("rational_arithmetic_unit_core: mismatch");
    $finish;
  end
endmodule

FILE: filelist.f
sv/rau_pkg.sv
sv/rau_div.sv
sv/rau_datapath.sv
sv/rau_ctrl.sv
sv/rational_arithmetic_unit_core.sv
tb/sv/testbench.sv
